// ===== rtl/jsl_pkg.sv =====
// ----------------------------------------------------------------------------
// jsl_pkg
// Types, register indexes, sequencer states and fixed-point helpers shared by
// the joint stress law block and its arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package jsl_pkg;

    localparam int CFG_W  = 40;
    localparam int CFG_AW = 3;

    localparam logic [CFG_AW-1:0] REG_YOUNG    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_POISSON  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MAX_COMP = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MAX_TENS = 3'd3;
    localparam logic [CFG_AW-1:0] REG_FRICTION = 3'd4;

    localparam logic [48:0] CAP48     = 49'h1_0000_0000_0000;
    localparam logic [49:0] POS_MAX   = 50'h0_7FFF_FFFF_FFFF;
    localparam logic [49:0] NEG_MAX   = 50'h0_8000_0000_0000;
    localparam logic [15:0] NU_NEG1   = 16'h8000;

    typedef struct packed {
        logic               func;
        logic               in_contact;
        logic signed [31:0] strain_shear_x;
        logic signed [31:0] strain_shear_y;
        logic signed [31:0] strain_normal;
    } in_t;

    typedef struct packed {
        logic signed [47:0] stress_shear_x;
        logic signed [47:0] stress_shear_y;
        logic signed [47:0] stress_normal;
        logic [39:0]        stiff_xx;
        logic [39:0]        stiff_nn;
        logic signed [47:0] stiff_xn;
        logic signed [47:0] stiff_yn;
        logic               is_broken;
        logic               saturated;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SX, ST_SY, ST_SN, ST_RX, ST_RY, ST_RN, ST_CPL,
        ST_SQX, ST_SQY, ST_SQRT, ST_CHKT, ST_CHKN, ST_MAXF, ST_GDIV,
        ST_FR, ST_QX, ST_FX, ST_QY, ST_FY, ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] n;
        logic [63:0] d;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] v;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic [47:0] val;
        logic        sat;
    } sgn_t;

    // product >> sh, capped at 2^48
    function automatic logic [48:0] sat_shr(input logic [127:0] p, input logic [6:0] sh);
        logic [127:0] r;
        r = p >> sh;
        return (r > {79'd0, CAP48}) ? CAP48 : r[48:0];
    endfunction

    // apply sign to a magnitude, clamping to the 48-bit signed range
    function automatic sgn_t signed_out(input logic neg, input logic [49:0] mag);
        sgn_t o;
        o.sat = 1'b0;
        if (!neg) begin
            if (mag > POS_MAX) begin
                o.val = POS_MAX[47:0];
                o.sat = 1'b1;
            end else begin
                o.val = mag[47:0];
            end
        end else begin
            if (mag > NEG_MAX) begin
                o.val = NEG_MAX[47:0];
                o.sat = 1'b1;
            end else begin
                o.val = 48'd0 - mag[47:0];
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jsl_mul.sv =====
// ----------------------------------------------------------------------------
// jsl_mul
// 64x64 -> 128 unsigned multiplier, one 32x32 partial product per cycle,
// partial products registered before they are accumulated.
// ----------------------------------------------------------------------------
`default_nettype none

module jsl_mul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire jsl_pkg::mul_req_t req,
    output jsl_pkg::mul_rsp_t      rsp
);
    import jsl_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic         pv_reg, pv_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [1:0]   sh_reg, sh_next;
    logic [63:0]  a_reg, a_next, b_reg, b_next, pp_reg, pp_next;
    logic [127:0] acc_reg, acc_next;
    logic [31:0]  a_half, b_half;
    logic [127:0] acc_add;

    always_comb begin
        a_half  = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half  = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        acc_add = {64'd0, pp_reg} << {sh_reg, 5'd0};

        busy_next = busy_reg;
        done_next = 1'b0;
        pv_next   = pv_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        pp_next   = pp_reg;
        acc_next  = acc_reg;

        if (req.start) begin
            busy_next = 1'b1;
            pv_next   = 1'b0;
            cnt_next  = 3'd0;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = 128'd0;
        end else if (busy_reg) begin
            if (pv_reg) begin
                acc_next = acc_reg + acc_add;
            end
            if (!cnt_reg[2]) begin
                pp_next  = a_half * b_half;
                sh_next  = {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0]};
                pv_next  = 1'b1;
                cnt_next = cnt_reg + 3'd1;
            end else begin
                busy_next = 1'b0;
                pv_next   = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pv_reg   <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            pv_reg   <= pv_next;
            cnt_reg  <= cnt_next;
        end
        sh_reg  <= sh_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/jsl_div.sv =====
// ----------------------------------------------------------------------------
// jsl_div
// 64 by 64 bit unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jsl_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire jsl_pkg::div_req_t req,
    output jsl_pkg::div_rsp_t      rsp
);
    import jsl_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next, quo_reg, quo_next, d_reg, d_next;
    logic [64:0] shifted;
    logic [65:0] diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[63]};
        diff      = {1'b0, shifted} - {2'b00, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        d_next    = d_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = 64'd0;
            quo_next  = req.n;
            d_next    = req.d;
        end else if (busy_reg) begin
            if (!diff[65]) begin
                rem_next = diff[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        d_reg   <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/jsl_sqrt.sv =====
// ----------------------------------------------------------------------------
// jsl_sqrt
// Floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jsl_sqrt (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire jsl_pkg::sqrt_req_t req,
    output jsl_pkg::sqrt_rsp_t      rsp
);
    import jsl_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next;
    logic [35:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [35:0] rem_sh, trial;

    always_comb begin
        rem_sh    = {rem_reg[33:0], v_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            v_next    = req.v;
            rem_next  = 36'd0;
            root_next = 32'd0;
        end else if (busy_reg) begin
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            v_next   = {v_reg[61:0], 2'b00};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/joint_stress_law.sv =====
// ----------------------------------------------------------------------------
// joint_stress_law
// Stress and tangent stiffness of an intact or broken joint interface, with
// Coulomb friction for a broken joint in contact and a break check on commit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  s_*       in   s_valid / s_ready  jsl_pkg::in_t
//  m_*       out  m_valid / m_ready  jsl_pkg::out_t
//  cfg_*     in   cfg_we             cfg_addr, cfg_data (no wait)
//
//  One word at a time: s_ready is high only while the sequencer is idle.
//  The shortest path is a commit on a broken joint; the longest is the
//  friction case: ten multiplies, a square root and three divides, all on
//  shared iterative units, plus the idle and result steps.
//  The result sits in an output register, so the next word is taken while it
//  waits for m_ready. Reset is synchronous, active low, and leaves the joint
//  intact and the configuration registers zero; the datapath is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_stress_law (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire jsl_pkg::in_t                 s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output jsl_pkg::out_t                     m_data,
    input  wire logic                         cfg_we,
    input  wire logic [jsl_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [jsl_pkg::CFG_W-1:0]    cfg_data
);
    import jsl_pkg::*;

    state_t      state_reg, state_next;
    logic        started_reg, started_next;
    logic [39:0] young_reg, maxc_reg, maxt_reg;
    logic [15:0] nu_reg;
    logic [23:0] mu_reg;
    logic        broken_reg, broken_next;
    logic        hit_reg, hit_next;
    logic        cmt_reg, cmt_next, ctc_reg, ctc_next;
    logic        nx_reg, nx_next, ny_reg, ny_next, nn_reg, nn_next;
    logic [31:0] mx_reg, mx_next, my_reg, my_next, mn_reg, mn_next;
    logic [63:0] sq_reg, sq_next;
    logic [31:0] t_reg, t_next;
    logic [49:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [48:0] sn_reg, sn_next, cpl_reg, cpl_next, maxf_reg, maxf_next;
    logic [48:0] f_reg, f_next;
    logic [63:0] g_reg, g_next, q_reg, q_next;
    out_t        out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    mul_req_t  mul_req;
    mul_rsp_t  mul_rsp;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    logic        is_mul, is_div, is_sqrt, op_fin, accept, emit;
    logic        mx_nz, my_nz, mu_nz, denom_zero;
    logic [63:0] eb;
    logic [16:0] denom;
    logic [48:0] fr;
    state_t      after_fr, after_fx;
    sgn_t        o_sx, o_sy, o_sn, o_cx, o_cy;
    logic        use_cpl;

    jsl_mul  u_mul  (.aclk(aclk), .aresetn(aresetn), .req(mul_req),  .rsp(mul_rsp));
    jsl_div  u_div  (.aclk(aclk), .aresetn(aresetn), .req(div_req),  .rsp(div_rsp));
    jsl_sqrt u_sqrt (.aclk(aclk), .aresetn(aresetn), .req(sqrt_req), .rsp(sqrt_rsp));

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;
    assign eb         = {54'd0, young_reg[39:30]};
    assign denom      = {nu_reg ^ NU_NEG1, 1'b0};
    assign denom_zero = (nu_reg == NU_NEG1);
    assign mx_nz      = (mx_reg != 32'd0);
    assign my_nz      = (my_reg != 32'd0);
    assign mu_nz      = (mu_reg != 24'd0);
    assign after_fr   = mx_nz ? ST_QX : (my_nz ? ST_QY : ST_DONE);
    assign after_fx   = my_nz ? ST_QY : ST_DONE;
    assign emit       = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    always_comb begin
        is_mul  = 1'b0;
        is_div  = 1'b0;
        is_sqrt = 1'b0;
        case (state_reg)
            ST_SX, ST_SY, ST_SN, ST_RX, ST_RY, ST_RN, ST_CPL, ST_SQX, ST_SQY,
            ST_CHKT, ST_CHKN, ST_MAXF, ST_FR, ST_FX, ST_FY: is_mul = 1'b1;
            ST_GDIV, ST_QX, ST_QY: is_div = 1'b1;
            ST_SQRT: is_sqrt = 1'b1;
            default: ;
        endcase
        op_fin = started_reg && ((is_mul && mul_rsp.done) || (is_div && div_rsp.done) ||
                                 (is_sqrt && sqrt_rsp.done));
    end

    // operand selection for the shared units
    always_comb begin
        mul_req.start  = is_mul && !started_reg;
        div_req.start  = is_div && !started_reg;
        sqrt_req.start = is_sqrt && !started_reg;
        sqrt_req.v     = sq_reg;
        mul_req.a      = 64'd0;
        mul_req.b      = 64'd0;
        div_req.n      = 64'd0;
        div_req.d      = 64'd0;
        case (state_reg)
            ST_SX:   begin mul_req.a = {24'd0, young_reg}; mul_req.b = {32'd0, mx_reg}; end
            ST_SY:   begin mul_req.a = {24'd0, young_reg}; mul_req.b = {32'd0, my_reg}; end
            ST_SN:   begin mul_req.a = {24'd0, young_reg}; mul_req.b = {32'd0, mn_reg}; end
            ST_RX:   begin mul_req.a = eb; mul_req.b = {32'd0, mx_reg}; end
            ST_RY:   begin mul_req.a = eb; mul_req.b = {32'd0, my_reg}; end
            ST_RN:   begin mul_req.a = eb; mul_req.b = {32'd0, mn_reg}; end
            ST_CPL:  begin mul_req.a = {24'd0, young_reg}; mul_req.b = {40'd0, mu_reg}; end
            ST_SQX:  begin mul_req.a = {32'd0, mx_reg}; mul_req.b = {32'd0, mx_reg}; end
            ST_SQY:  begin mul_req.a = {32'd0, my_reg}; mul_req.b = {32'd0, my_reg}; end
            ST_CHKT: begin mul_req.a = {24'd0, young_reg}; mul_req.b = {32'd0, t_reg}; end
            ST_CHKN: begin mul_req.a = {24'd0, young_reg}; mul_req.b = {32'd0, mn_reg}; end
            ST_MAXF: begin mul_req.a = {40'd0, mu_reg}; mul_req.b = {15'd0, sn_reg}; end
            ST_FR:   begin mul_req.a = g_reg; mul_req.b = {32'd0, t_reg}; end
            ST_FX, ST_FY: begin mul_req.a = {15'd0, f_reg}; mul_req.b = q_reg; end
            ST_GDIV: begin div_req.n = {9'd0, young_reg, 15'd0}; div_req.d = {47'd0, denom}; end
            ST_QX:   begin div_req.n = {mx_reg, 32'd0}; div_req.d = {32'd0, t_reg}; end
            ST_QY:   begin div_req.n = {my_reg, 32'd0}; div_req.d = {32'd0, t_reg}; end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.func) begin
                        state_next = broken_reg ? ST_DONE : ST_SQX;
                    end else if (!broken_reg) begin
                        state_next = ST_SX;
                    end else begin
                        state_next = s_data.in_contact ? ST_CPL : ST_RX;
                    end
                end
            end
            ST_SX:   if (op_fin) state_next = ST_SY;
            ST_SY:   if (op_fin) state_next = ST_SN;
            ST_SN:   if (op_fin) state_next = broken_reg ? ST_RX : ST_DONE;
            ST_CPL:  if (op_fin) state_next = ST_SN;
            ST_RX:   if (op_fin) state_next = ST_RY;
            ST_RY: begin
                if (op_fin) begin
                    if (!ctc_reg) begin
                        state_next = ST_RN;
                    end else begin
                        state_next = mu_nz ? ST_SQX : ST_DONE;
                    end
                end
            end
            ST_RN:   if (op_fin) state_next = ST_DONE;
            ST_SQX:  if (op_fin) state_next = ST_SQY;
            ST_SQY:  if (op_fin) state_next = ST_SQRT;
            ST_SQRT: if (op_fin) state_next = cmt_reg ? ST_CHKT : ST_MAXF;
            ST_CHKT: if (op_fin) state_next = ST_CHKN;
            ST_CHKN: if (op_fin) state_next = ST_DONE;
            ST_MAXF: if (op_fin) state_next = denom_zero ? after_fr : ST_GDIV;
            ST_GDIV: if (op_fin) state_next = ST_FR;
            ST_FR:   if (op_fin) state_next = after_fr;
            ST_QX:   if (op_fin) state_next = ST_FX;
            ST_FX:   if (op_fin) state_next = after_fx;
            ST_QY:   if (op_fin) state_next = ST_FY;
            ST_FY:   if (op_fin) state_next = ST_DONE;
            ST_DONE: if (emit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // result word
    always_comb begin
        use_cpl = !cmt_reg && broken_reg && ctc_reg;
        o_sx    = signed_out(nx_reg, sx_reg);
        o_sy    = signed_out(ny_reg, sy_reg);
        o_sn    = signed_out(nn_reg, {1'b0, sn_reg});
        o_cx    = signed_out(!nx_reg, {1'b0, cpl_reg});
        o_cy    = signed_out(!ny_reg, {1'b0, cpl_reg});
        out_next = '0;
        out_next.is_broken = broken_reg | hit_reg;
        if (!cmt_reg) begin
            out_next.stress_shear_x = o_sx.val;
            out_next.stress_shear_y = o_sy.val;
            out_next.stress_normal  = o_sn.val;
            out_next.stiff_xx       = broken_reg ? eb[39:0] : young_reg;
            out_next.stiff_nn       = (broken_reg && !ctc_reg) ? eb[39:0] : young_reg;
            out_next.stiff_xn       = (use_cpl && mx_nz) ? o_cx.val : 48'd0;
            out_next.stiff_yn       = (use_cpl && my_nz) ? o_cy.val : 48'd0;
            out_next.saturated      = o_sx.sat | o_sy.sat | o_sn.sat |
                                      (use_cpl && mx_nz && o_cx.sat) |
                                      (use_cpl && my_nz && o_cy.sat);
        end
    end

    // datapath and control registers
    always_comb begin
        started_next   = started_reg;
        broken_next    = broken_reg;
        hit_next       = hit_reg;
        cmt_next       = cmt_reg;
        ctc_next       = ctc_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nn_next        = nn_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mn_next        = mn_reg;
        sq_next        = sq_reg;
        t_next         = t_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sn_next        = sn_reg;
        cpl_next       = cpl_reg;
        maxf_next      = maxf_reg;
        f_next         = f_reg;
        g_next         = g_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg && !m_ready;
        fr             = sat_shr(mul_rsp.p, 7'd24);

        if ((is_mul || is_div || is_sqrt) && !started_reg) begin
            started_next = 1'b1;
        end
        if (op_fin) begin
            started_next = 1'b0;
        end

        if (accept) begin
            cmt_next = s_data.func;
            ctc_next = s_data.in_contact;
            nx_next  = s_data.strain_shear_x[31];
            ny_next  = s_data.strain_shear_y[31];
            nn_next  = s_data.strain_normal[31];
            mx_next  = s_data.strain_shear_x[31] ? 32'd0 - s_data.strain_shear_x
                                                 : s_data.strain_shear_x;
            my_next  = s_data.strain_shear_y[31] ? 32'd0 - s_data.strain_shear_y
                                                 : s_data.strain_shear_y;
            mn_next  = s_data.strain_normal[31] ? 32'd0 - s_data.strain_normal
                                                : s_data.strain_normal;
            hit_next = 1'b0;
        end

        if (op_fin) begin
            case (state_reg)
                ST_SX:   sx_next   = {1'b0, sat_shr(mul_rsp.p, 7'd24)};
                ST_SY:   sy_next   = {1'b0, sat_shr(mul_rsp.p, 7'd24)};
                ST_SN:   sn_next   = sat_shr(mul_rsp.p, 7'd24);
                ST_RX:   sx_next   = mul_rsp.p[73:24];
                ST_RY:   sy_next   = mul_rsp.p[73:24];
                ST_RN:   sn_next   = mul_rsp.p[72:24];
                ST_CPL:  cpl_next  = sat_shr(mul_rsp.p, 7'd16);
                ST_SQX:  sq_next   = mul_rsp.p[63:0];
                ST_SQY:  sq_next   = sq_reg + mul_rsp.p[63:0];
                ST_SQRT: t_next    = sqrt_rsp.root;
                ST_CHKT: hit_next  = hit_reg | (mul_rsp.p > {64'd0, maxt_reg, 24'd0});
                ST_CHKN: hit_next  = hit_reg | (mul_rsp.p >
                                     {64'd0, (ctc_reg ? maxc_reg : maxt_reg), 24'd0});
                ST_MAXF: begin
                    maxf_next = sat_shr(mul_rsp.p, 7'd16);
                    f_next    = sat_shr(mul_rsp.p, 7'd16);
                end
                ST_GDIV: g_next    = div_rsp.q;
                ST_FR:   f_next    = (fr < maxf_reg) ? fr : maxf_reg;
                ST_QX, ST_QY: q_next = div_rsp.q;
                ST_FX:   sx_next   = sx_reg + {1'b0, sat_shr(mul_rsp.p, 7'd32)};
                ST_FY:   sy_next   = sy_reg + {1'b0, sat_shr(mul_rsp.p, 7'd32)};
                default: ;
            endcase
        end

        if (emit) begin
            out_valid_next = 1'b1;
            broken_next    = broken_reg | hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            broken_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            young_reg     <= 40'd0;
            nu_reg        <= 16'd0;
            maxc_reg      <= 40'd0;
            maxt_reg      <= 40'd0;
            mu_reg        <= 24'd0;
        end else begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            broken_reg    <= broken_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_YOUNG:    young_reg <= cfg_data;
                    REG_POISSON:  nu_reg    <= cfg_data[15:0];
                    REG_MAX_COMP: maxc_reg  <= cfg_data;
                    REG_MAX_TENS: maxt_reg  <= cfg_data;
                    REG_FRICTION: mu_reg    <= cfg_data[23:0];
                    default: ;
                endcase
            end
        end
        cmt_reg  <= cmt_next;
        ctc_reg  <= ctc_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        nn_reg   <= nn_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mn_reg   <= mn_next;
        sq_reg   <= sq_next;
        t_reg    <= t_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        sn_reg   <= sn_next;
        cpl_reg  <= cpl_next;
        maxf_reg <= maxf_next;
        f_reg    <= f_next;
        g_reg    <= g_next;
        q_reg    <= q_next;
        if (emit) begin
            out_reg <= out_next;
        end
    end

    // a broken joint stays broken
    a_broken_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        broken_reg |=> broken_reg)
        else $error("joint state cleared");

    // only one shared unit is launched at a time
    a_one_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mul_req.start, div_req.start, sqrt_req.start}))
        else $error("two units launched together");

    // friction coupling only appears for a broken joint
    a_intact_no_cpl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_broken) |-> (m_data.stiff_xn == 48'd0 &&
                                             m_data.stiff_yn == 48'd0))
        else $error("coupling on intact joint");

    // no new word is taken until the sequencer has been through its result step
    a_done_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !emit) |=> (state_reg == ST_DONE))
        else $error("result step left without emitting");

endmodule

`default_nettype wire

// ===== tb/sv/tb_joint_stress_law.sv =====
// ----------------------------------------------------------------------------
// tb_joint_stress_law
// Self-checking bench for the joint stress law block. A scoreboard predicts
// stress, stiffness and break state for every accepted word in 64-bit and
// 128-bit arithmetic and checks each result word. Several register settings
// are run with the joint intact, then broken, under varying idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_joint_stress_law;
    timeunit 1ns;
    timeprecision 1ps;

    import jsl_pkg::*;

    localparam logic [63:0] CAP_48 = 64'h1_0000_0000_0000;
    localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000;
    localparam logic [39:0] ALL40 = 40'hFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 20000;

    class joint_scoreboard;
        logic [39:0] e_mod, c_lim, t_lim;
        logic [15:0] nu;
        logic [23:0] mu;
        logic broken;
        logic clamped;
        out_t expected_q[$];
        int errors;

        function new();
            e_mod = '0; c_lim = '0; t_lim = '0; nu = '0; mu = '0;
            broken = 1'b0;
            errors = 0;
        endfunction

        function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
            logic [127:0] p;
            p = ({64'd0, a} * {64'd0, b}) >> sh;
            return (p > {64'd0, CAP_48}) ? CAP_48 : p[63:0];
        endfunction

        function logic over_limit(logic [63:0] a, logic [63:0] b, logic [39:0] lim);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p > ({88'd0, lim} << 24);
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] r, cand;
            r = '0;
            for (int i = 31; i >= 0; i--) begin
                cand = r | (64'd1 << i);
                if (cand * cand <= v) r = cand;
            end
            return r;
        endfunction

        function logic [47:0] with_sign(logic neg, logic [63:0] mag);
            if (!neg) begin
                if (mag > POS_LIM) begin
                    clamped = 1'b1;
                    return POS_LIM[47:0];
                end
                return mag[47:0];
            end
            if (mag > NEG_LIM) begin
                clamped = 1'b1;
                return NEG_LIM[47:0];
            end
            return 48'd0 - mag[47:0];
        endfunction

        function void split(logic [31:0] raw, output logic neg, output logic [63:0] mag);
            neg = raw[31];
            mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
        endfunction

        // stress and stiffness for one word; updates the break state
        function out_t joint_response(in_t w);
            out_t o;
            logic nx, ny, nn;
            logic [63:0] mx, my, mn, e, eb, t, cpl, maxf, denom, g, fr, f;
            logic [63:0] sxm, sym, snm, kx, kn;
            o = '0;
            clamped = 1'b0;
            e = {24'd0, e_mod};
            eb = e >> 30;
            split(w.strain_shear_x, nx, mx);
            split(w.strain_shear_y, ny, my);
            split(w.strain_normal, nn, mn);
            if (w.func) begin
                if (!broken) begin
                    t = root(mx * mx + my * my);
                    if (over_limit(e, t, t_lim) ||
                        over_limit(e, mn, w.in_contact ? c_lim : t_lim))
                        broken = 1'b1;
                end
                o.is_broken = broken;
                return o;
            end
            if (!broken) begin
                kx = e; kn = e;
                sxm = mul_shift(e, mx, 24);
                sym = mul_shift(e, my, 24);
                snm = mul_shift(e, mn, 24);
            end else if (!w.in_contact) begin
                kx = eb; kn = eb;
                sxm = (eb * mx) >> 24;
                sym = (eb * my) >> 24;
                snm = (eb * mn) >> 24;
            end else begin
                cpl = mul_shift(e, {40'd0, mu}, 16);
                kx = eb; kn = e;
                snm = mul_shift(e, mn, 24);
                if (mx != 0) o.stiff_xn = with_sign(!nx, cpl);
                if (my != 0) o.stiff_yn = with_sign(!ny, cpl);
                if (mu == 0) begin
                    sxm = (eb * mx) >> 24;
                    sym = (eb * my) >> 24;
                end else begin
                    t = root(mx * mx + my * my);
                    maxf = mul_shift({40'd0, mu}, snm, 16);
                    denom = 64'd2 * {48'd0, nu ^ NU_NEG1};
                    // nu of -1: shear modulus unbounded, friction at its cap
                    if (denom == 0) begin
                        f = maxf;
                    end else begin
                        g = (e << 15) / denom;
                        fr = mul_shift(g, t, 24);
                        f = (fr < maxf) ? fr : maxf;
                    end
                    sxm = 0; sym = 0;
                    if (mx != 0 && t != 0)
                        sxm = ((eb * mx) >> 24) + mul_shift(f, (mx << 32) / t, 32);
                    if (my != 0 && t != 0)
                        sym = ((eb * my) >> 24) + mul_shift(f, (my << 32) / t, 32);
                end
            end
            o.stress_shear_x = with_sign(nx, sxm);
            o.stress_shear_y = with_sign(ny, sym);
            o.stress_normal = with_sign(nn, snm);
            o.stiff_xx = kx[39:0];
            o.stiff_nn = kn[39:0];
            o.is_broken = broken;
            o.saturated = clamped;
            return o;
        endfunction

        function void note_word(in_t w);
            expected_q.push_back(joint_response(w));
        endfunction

        function void check_word(out_t got);
            out_t exp_o;
            string bad;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result word %h", got);
                return;
            end
            exp_o = expected_q.pop_front();
            bad = "";
            if (got.stress_shear_x !== exp_o.stress_shear_x) bad = {bad, " stress_shear_x"};
            if (got.stress_shear_y !== exp_o.stress_shear_y) bad = {bad, " stress_shear_y"};
            if (got.stress_normal !== exp_o.stress_normal) bad = {bad, " stress_normal"};
            if (got.stiff_xx !== exp_o.stiff_xx) bad = {bad, " stiff_xx"};
            if (got.stiff_nn !== exp_o.stiff_nn) bad = {bad, " stiff_nn"};
            if (got.stiff_xn !== exp_o.stiff_xn) bad = {bad, " stiff_xn"};
            if (got.stiff_yn !== exp_o.stiff_yn) bad = {bad, " stiff_yn"};
            if (got.is_broken !== exp_o.is_broken) bad = {bad, " is_broken"};
            if (got.saturated !== exp_o.saturated) bad = {bad, " saturated"};
            if (bad != "") begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: mismatch in%s\n  exp %h\n  got %h", bad, exp_o, got);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    joint_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    joint_stress_law DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // result side: checks, random stall and long hold-off
    always @(posedge aclk) begin
        if (m_valid && m_ready) sb.check_word(m_data);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [39:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_YOUNG: sb.e_mod = val;
            REG_POISSON: sb.nu = val[15:0];
            REG_MAX_COMP: sb.c_lim = val;
            REG_MAX_TENS: sb.t_lim = val;
            REG_FRICTION: sb.mu = val[23:0];
            default: ;
        endcase
    endtask

    task automatic set_law(logic [39:0] e, logic [15:0] nu, logic [39:0] cmax,
                           logic [39:0] tmax, logic [23:0] mu);
        @(posedge aclk);
        write_reg(REG_YOUNG, e);
        write_reg(REG_POISSON, {24'd0, nu});
        write_reg(REG_MAX_COMP, cmax);
        write_reg(REG_MAX_TENS, tmax);
        write_reg(REG_FRICTION, {16'd0, mu});
    endtask

    task automatic send_word(in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    task automatic drain();
        @(posedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_strain();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return $urandom();
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return 32'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
            4: return 32'($signed($urandom_range(32'h2000)) - 32'sh1000);
            default: return 32'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
        endcase
    endfunction

    function automatic in_t pick_word(int commit_pct);
        in_t w;
        w.func = ($urandom_range(99) < commit_pct);
        w.in_contact = ($urandom_range(99) < 70);
        w.strain_shear_x = pick_strain();
        w.strain_shear_y = pick_strain();
        w.strain_normal = pick_strain();
        return w;
    endfunction

    function automatic in_t mk(logic fn, logic ct, logic [31:0] x, logic [31:0] y,
                               logic [31:0] n);
        in_t w;
        w.func = fn; w.in_contact = ct;
        w.strain_shear_x = x; w.strain_shear_y = y; w.strain_normal = n;
        return w;
    endfunction

    task automatic run_random(int n, int commit_pct, int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
        for (int i = 0; i < n; i++) send_word(pick_word(commit_pct));
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // intact joint, registers at reset values, then a real setting
        send_word(mk(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000));
        send_word(mk(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        drain();
        set_law(ALL40, 16'h3FFF, ALL40, ALL40, 24'hFF_FFFF);
        send_word(mk(1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_word(mk(1'b0, 1'b1, 32'h0000_0001, 32'h0, 32'h8000_0000));
        send_word(mk(1'b0, 1'b1, 32'h0, 32'h0, 32'h0));
        drain();

        set_law(40'h10_0000, 16'h2000, ALL40, ALL40, 24'h01_8000);
        run_random(130, 25, 0);
        set_law(ALL40, 16'h0000, ALL40, ALL40, 24'($urandom()));
        run_random(130, 0, 1);
        set_law({8'($urandom_range(255)), $urandom()} >> 10, 16'($urandom()),
                {8'($urandom_range(255)), $urandom()}, {8'($urandom_range(255)), $urandom()},
                24'($urandom()));
        run_random(130, 20, 2);

        // force the break, then the broken-joint special cases
        set_law(40'h1_0000_0000, NU_NEG1, 40'd0, 40'd0, 24'h00_8000);
        send_word(mk(1'b1, 1'b1, 32'h0100_0000, 32'h0, 32'h0));
        send_word(mk(1'b1, 1'b0, 32'h0, 32'h0, 32'h0));
        send_word(mk(1'b0, 1'b1, 32'h0, 32'h0100_0000, 32'hFF00_0000));
        send_word(mk(1'b0, 1'b1, 32'h0200_0000, 32'h0, 32'hFF00_0000));
        send_word(mk(1'b0, 1'b1, 32'h0, 32'h0, 32'h8000_0000));
        send_word(mk(1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        drain();
        write_reg(REG_FRICTION, 40'd0);
        send_word(mk(1'b0, 1'b1, 32'h8000_0000, 32'h0300_0000, 32'hF000_0000));
        send_word(mk(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        drain();
        write_reg(REG_POISSON, 40'h3FFF);
        write_reg(REG_FRICTION, 40'hFF_FFFF);
        send_word(mk(1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_word(mk(1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
        drain();

        // long receiver hold-off while the sender keeps offering words
        set_law(ALL40, NU_NEG1, 40'($urandom()), 40'($urandom()), 24'hFF_FFFF);
        hold_left <= 600;
        run_random(140, 10, 0);
        set_law({8'($urandom_range(255)), $urandom()}, 16'h3FFF, 40'd0, 40'd0, 24'd0);
        run_random(140, 10, 1);
        set_law({8'($urandom_range(255)), $urandom()}, 16'($urandom()), 40'd0, 40'd0,
                24'($urandom()));
        run_random(140, 10, 2);
        set_law(40'($urandom_range(32'h3FFF_FFFF)), 16'h8001, 40'd0, 40'd0,
                24'($urandom()));
        run_random(140, 10, 3);
        set_law($urandom_range(1) ? 40'd0 : {8'($urandom_range(255)), $urandom()},
                16'($urandom()), 40'd0, 40'd0, 24'($urandom_range(24'h0F_FFFF)));
        run_random(140, 10, 0);

        repeat (400) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== joint_stress_law.f =====
rtl/jsl_pkg.sv
rtl/jsl_mul.sv
rtl/jsl_div.sv
rtl/jsl_sqrt.sv
rtl/joint_stress_law.sv
tb/sv/tb_joint_stress_law.sv
